### rtl/core/tla_pkg.sv
// Shared types and constants for the tour length accumulator.
package tla_pkg;

  localparam int COORD_W    = 20;
  localparam int SUM_W      = 28;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int WORK_W     = 42;
  localparam int ROOT_W     = 21;
  localparam int ROOT_STEPS = 21;
  localparam int ITER_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [WORK_W-1:0] ROOT_BIT_INIT = WORK_W'(1) << (2 * (ROOT_STEPS - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } tla_state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic add;
    logic root_step;
    logic accumulate;
    logic emit;
  } tla_cmd_t;

  typedef struct packed {
    logic have_previous;
    logic last;
    logic out_free;
  } tla_status_t;

endpackage

### rtl/core/tla_ctrl.sv
// Sequencer for one tour point: capture, square, add, root iterations, accumulate, emit.
module tla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  tla_pkg::tla_status_t status,
  output tla_pkg::tla_cmd_t    cmd
);
  import tla_pkg::*;

  tla_state_t        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // first point of a tour is only stored
          if (status.have_previous) state_next = ST_SQUARE;
          else if (in_last)         state_next = ST_EMIT;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        iter_next  = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (iter == ITER_W'(ROOT_STEPS - 1)) state_next = ST_ACC;
        else                                 iter_next  = iter + 1'b1;
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = status.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/tla_dp.sv
// Datapath: previous point, squared distance, bit-serial square root, saturating sum, output register.
module tla_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tla_pkg::COORD_W-1:0]  x_coord,
  input  logic [tla_pkg::COORD_W-1:0]  y_coord,
  input  logic                         last_point,
  input  tla_pkg::tla_cmd_t            cmd,
  output tla_pkg::tla_status_t         status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [tla_pkg::SUM_W-1:0]    total_length,
  output logic                         saturated
);
  import tla_pkg::*;

  logic [COORD_W-1:0] previous_x, previous_y;
  logic               have_previous;
  logic               last;
  logic [COORD_W-1:0] dx, dy;
  logic [PROD_W-1:0]  px, py;
  logic [WORK_W-1:0]  rem, root, bitv;
  logic [SUM_W-1:0]   running_sum;
  logic               sum_saturated;

  logic [WORK_W-1:0]  trial;
  logic [SUM_W:0]     sum_wide;

  assign trial    = root + bitv;
  assign sum_wide = {1'b0, running_sum} + (SUM_W + 1)'(root[ROOT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_x    <= '0;
      previous_y    <= '0;
      have_previous <= 1'b0;
      running_sum   <= '0;
      sum_saturated <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        previous_x    <= x_coord;
        previous_y    <= y_coord;
        have_previous <= 1'b1;
      end
      if (cmd.accumulate) begin
        if (sum_wide >= {1'b0, SUM_MAX}) begin
          running_sum   <= SUM_MAX;
          sum_saturated <= 1'b1;
        end else begin
          running_sum <= sum_wide[SUM_W-1:0];
        end
      end
      if (cmd.emit) begin
        // tour finished: clear the previous point, sum and flag, and raise output valid
        previous_x    <= '0;
        previous_y    <= '0;
        have_previous <= 1'b0;
        running_sum   <= '0;
        sum_saturated <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last <= last_point;
      dx   <= (x_coord >= previous_x) ? x_coord - previous_x : previous_x - x_coord;
      dy   <= (y_coord >= previous_y) ? y_coord - previous_y : previous_y - y_coord;
    end
    if (cmd.square) begin
      px <= PROD_W'(dx) * PROD_W'(dx);
      py <= PROD_W'(dy) * PROD_W'(dy);
    end
    if (cmd.add) begin
      rem  <= WORK_W'(px) + WORK_W'(py);
      root <= '0;
      bitv <= ROOT_BIT_INIT;
    end
    if (cmd.root_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.emit) begin
      total_length <= running_sum;
      saturated    <= sum_saturated;
    end
  end

  assign status.have_previous = have_previous;
  assign status.last          = last;
  assign status.out_free      = !out_valid || out_ready;

endmodule

### rtl/core/tour_length_accumulator_top.sv
// Top level of the tour length accumulator: stream ports, sequencer and datapath.
// Later points pass through capture, square, add, 21 root iterations and accumulate; the
// first point of a tour is only captured, and a last point also passes through the emit step.
// The total is registered by the emit step after a last point is accepted, also for a single-point tour.
// A new tour starts while a total waits; the next total stalls in emit until it is taken.
// rst (synchronous, active high) clears the previous point, sum, flag and output valid.
module tour_length_accumulator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tla_pkg::IN_DATA_W-1:0]   s_tdata,   // [19:0] x_coord, [39:20] y_coord
  input  logic                            s_tlast,   // last_point
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tla_pkg::OUT_DATA_W-1:0]  m_tdata    // [27:0] total_length, [28] saturated
);
  import tla_pkg::*;

  tla_cmd_t          cmd;
  tla_status_t       status;
  logic [SUM_W-1:0]  total_length;
  logic              saturated;

  tla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tla_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .x_coord      (s_tdata[COORD_W-1:0]),
    .y_coord      (s_tdata[2*COORD_W-1:COORD_W]),
    .last_point   (s_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .total_length (total_length),
    .saturated    (saturated)
  );

  assign m_tdata = {{(OUT_DATA_W - SUM_W - 1){1'b0}}, saturated, total_length};

  // a last point always leaves the block busy in the cycle after it is taken
  a_last_busy : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken straight after a last point");

  a_sat_max : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[SUM_W] |-> m_tdata[SUM_W-1:0] == SUM_MAX)
    else $error("saturated flag without saturated total");

  a_emit_src : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("output valid without an emit");

endmodule

### verif/tour_length_accumulator_top_tb.sv
// Self-checking testbench for the tour length accumulator: directed tours, saturation, back-pressure and random tours.
module tour_length_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tla_pkg::*;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam int unsigned RANDOM_POINTS = 750;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned DRAIN_MARGIN  = 40;   // settle time after all totals are drained
  localparam int unsigned PRINT_CAP     = 50;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             sat;
  } tour_total_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic [COORD_W-1:0] pt_prev_x = '0;
  logic [COORD_W-1:0] pt_prev_y = '0;
  logic               pt_have   = 1'b0;
  logic [SUM_W-1:0]   pt_sum    = '0;
  logic               pt_sat    = 1'b0;
  tour_total_t        totals_due[$];
  tour_total_t        total_want;

  // stimulus state
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;
  logic               tx_burst = 1'b0;
  logic               rx_eager = 1'b0;
  logic               hold_req = 1'b0;
  int unsigned        rx_wait  = 0;
  int unsigned        idle_cycles = 0;

  int unsigned points_sent = 0;
  int unsigned tours_sent  = 0;
  int unsigned totals_seen = 0;
  int unsigned sat_tours   = 0;
  int unsigned holds_done  = 0;
  int unsigned mismatches  = 0;

  tour_length_accumulator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor square root, built up one root bit at a time from the top
  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [WORK_W-1:0] n);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      if (WORK_W'(trial) * WORK_W'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_point(input logic [COORD_W-1:0] x, y, input logic last);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [SUM_W:0]     sum;
    if (pt_have) begin
      dx  = (x >= pt_prev_x) ? x - pt_prev_x : pt_prev_x - x;
      dy  = (y >= pt_prev_y) ? y - pt_prev_y : pt_prev_y - y;
      sum = (SUM_W+1)'(pt_sum)
          + (SUM_W+1)'(floor_sqrt(WORK_W'(dx) * WORK_W'(dx) + WORK_W'(dy) * WORK_W'(dy)));
      if (sum >= (SUM_W+1)'(SUM_MAX)) begin
        sum    = (SUM_W+1)'(SUM_MAX);
        pt_sat = 1'b1;
      end
      pt_sum = sum[SUM_W-1:0];
    end
    pt_prev_x = x;
    pt_prev_y = y;
    pt_have   = 1'b1;
    if (last) begin
      totals_due.push_back('{total: pt_sum, sat: pt_sat});
      if (pt_sat) sat_tours++;
      tours_sent++;
      pt_prev_x = '0;
      pt_prev_y = '0;
      pt_have   = 1'b0;
      pt_sum    = '0;
      pt_sat    = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    mismatches++;
    // keep the log short on a badly broken design
    if (mismatches <= PRINT_CAP)
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_point(input logic [COORD_W-1:0] x, y, input logic last);
    int unsigned gap;
    gap = tx_burst ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    accumulate_point(x, y, last);
    last_x = x;
    last_y = y;
    points_sent++;
  endtask

  task automatic sender_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  task automatic wait_drained();
    sender_quiet();
    while (totals_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, eager stretches and one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_wait  = HOLD_CYCLES;
      holds_done++;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else if (!rx_eager && $urandom_range(99) < 25) begin
      rx_wait  = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (totals_due.size() == 0) begin
        report_mismatch("total with nothing due", m_tdata, 0);
      end else begin
        total_want = totals_due.pop_front();
        totals_seen++;
        if (m_tdata[SUM_W-1:0] !== total_want.total)
          report_mismatch("total_length", 32'(m_tdata[SUM_W-1:0]), 32'(total_want.total));
        if (m_tdata[SUM_W] !== total_want.sat)
          report_mismatch("saturated", 32'(m_tdata[SUM_W]), 32'(total_want.sat));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_single_point_tours();
    send_point('0, '0, 1'b1);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX, '0, 1'b1);
  endtask

  task automatic test_segment_lengths();
    // opposite corners both ways
    send_point('0, '0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX, '0, 1'b0);
    send_point('0, COORD_MAX, 1'b1);
    // 3-4-5, repeated point, an x-only step, root of 2 truncating to 1
    send_point('0, '0, 1'b0);
    send_point(20'd3, 20'd4, 1'b0);
    send_point(20'd3, 20'd4, 1'b0);
    send_point('0, 20'd4, 1'b0);
    send_point(20'd1, 20'd5, 1'b0);
    send_point(20'd524288, 20'd5, 1'b1);
    // x only, y only, alternating bit patterns
    send_point('0, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MAX, '0, 1'b1);
    send_point(20'hAAAAA, 20'h55555, 1'b0);
    send_point(20'h55555, 20'hAAAAA, 1'b1);
  endtask

  task automatic test_saturation();
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               corner;
    int unsigned        r;
    int unsigned        step;
    // hop between corners until close, then vertical steps land exactly on the maximum
    cx = '0;
    cy = '0;
    corner = 1'b0;
    send_point(cx, cy, 1'b0);
    while (SUM_MAX - pt_sum > 3000000) begin
      corner = !corner;
      cx = corner ? COORD_MAX : '0;
      cy = cx;
      send_point(cx, cy, 1'b0);
    end
    r = 32'(SUM_MAX - pt_sum);
    while (r != 0) begin
      step = (r > 500000) ? 500000 : r;
      cy = (cy >= 20'd524288) ? cy - COORD_W'(step) : cy + COORD_W'(step);
      send_point(cx, cy, 1'b0);
      r = 32'(SUM_MAX - pt_sum);
    end
    send_point(cx, cy, 1'b0);
    send_point(~cx, ~cy, 1'b1);
    // plain corner hopping that overshoots the maximum
    for (int i = 0; i < 190; i++)
      send_point((i % 2) ? COORD_MAX : '0, (i % 2) ? COORD_MAX : '0, i == 189);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    tx_burst = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_point(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
      send_point(COORD_W'($urandom), COORD_W'($urandom), 1'b1);
    end
    tx_burst = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_point(20'd100, 20'd200, 1'b0);
    send_point(20'd400, 20'd600, 1'b0);
    send_point(20'd1000, 20'd200, 1'b1);
    wait_drained();
    send_point(20'd7, 20'd9, 1'b0);
    send_point(20'd7, 20'd9, 1'b0);
    send_point(20'd8, 20'd10, 1'b1);
    wait_drained();
  endtask

  function automatic logic [COORD_W-1:0] rand_axis(input logic [COORD_W-1:0] prev,
                                                   input logic hop);
    int unsigned r;
    int          v;
    if (hop) return $urandom_range(1) ? COORD_MAX : '0;
    r = $urandom_range(99);
    if (r < 40) return COORD_W'($urandom);
    if (r < 65) begin
      v = int'(prev) + int'($urandom_range(511)) - 256;
      if (v < 0) v = 0;
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      return COORD_W'(v);
    end
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return 20'd1;
        2:       return COORD_MAX - 1;
        default: return COORD_MAX;
      endcase
    end
    if (r < 90) return prev;
    return COORD_W'(1) << $urandom_range(COORD_W - 1);
  endfunction

  function automatic int unsigned pick_tour_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6, 1);
    if (r < 92) return $urandom_range(40, 7);
    return $urandom_range(128, 41);
  endfunction

  task automatic test_random_tours();
    int unsigned budget;
    int unsigned len;
    logic        hop;
    budget = 0;
    while (budget < RANDOM_POINTS) begin
      tx_burst = ($urandom_range(99) < 15);
      rx_eager = ($urandom_range(99) < 15);
      hop      = ($urandom_range(99) < 10);
      len      = pick_tour_len();
      for (int unsigned i = 0; i < len; i++)
        send_point(rand_axis(last_x, hop), rand_axis(last_y, hop), i == len - 1);
      budget += len;
    end
    tx_burst = 1'b0;
    rx_eager = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_point_tours();
    test_segment_lengths();
    test_saturation();
    test_output_hold_off();
    test_drain_pause();
    test_random_tours();

    wait_drained();
    repeat (DRAIN_MARGIN) @(posedge clk);

    $display("sent %0d points in %0d tours; %0d totals checked, %0d of them saturated",
             points_sent, tours_sent, totals_seen, sat_tours);
    $display("random gaps on both sides, %0d long output hold-off(s), %0d mismatch(es)",
             holds_done, mismatches);
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### tour_length_accumulator_top.f
rtl/core/tla_pkg.sv
rtl/core/tla_ctrl.sv
rtl/core/tla_dp.sv
rtl/core/tour_length_accumulator_top.sv
verif/tour_length_accumulator_top_tb.sv
